FILE: rtl/tensor_contraction_engine_assert.svh
// Assertion macros for the tensor contraction engine.
`ifndef TENSOR_CONTRACTION_ENGINE_ASSERT_SVH
`define TENSOR_CONTRACTION_ENGINE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbl failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

FILE: rtl/tce_pkg.sv
package tce_pkg;

  localparam int unsigned ADepth    = 1024;
  localparam int unsigned BDepth    = 1024;
  localparam int unsigned MaxDim    = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned CntW      = 7;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned AccW      = 80;
  // Addresses are computed wide enough to never wrap (64^4 fits in 25 bits).
  localparam int unsigned WAddrW    = 26;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_OUTER  = 2'd0,
    MODE_MATVEC = 2'd1,
    MODE_MATMUL = 2'd2,
    MODE_COPY   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_BATCH  = 3'd1,
    CFG_ROW    = 3'd2,
    CFG_INNER  = 3'd3,
    CFG_SLICE  = 3'd4,
    CFG_COL    = 3'd5,
    CFG_VBATCH = 3'd6
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,   // bi*row + ri
    ST_MUL1B,  // bi*slice + si
    ST_MUL2,   // A base: *inner
    ST_MUL2B,  // B slice: *inner
    ST_MUL3,   // B: *col + ci
    ST_MUL4,   // B base, matmul span
    ST_CHECK,  // range checks
    ST_RDREQ,  // issue operand reads
    ST_MAC,    // multiply-accumulate loop
    ST_DRAIN,  // last products
    ST_FINISH, // shift and saturate
    ST_COPY
  } state_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic [AddrW-1:0]         address;
    logic signed [DataWidth-1:0] value;
    logic [IdxW-1:0]          batch_idx;
    logic [IdxW-1:0]          slice_idx;
    logic [IdxW-1:0]          row_idx;
    logic [IdxW-1:0]          col_idx;
  } item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result;
    logic                        error;
  } res_t;

  // Controls from the sequencer to the MAC unit.
  typedef struct packed {
    logic clear;
    logic acc_en;
  } mac_ctl_t;

  function automatic logic dim_ok(logic [CntW-1:0] n);
    return (n != '0) && ({25'd0, n} <= MaxDim);
  endfunction

endpackage

FILE: rtl/tce_mac.sv
module tce_mac
  import tce_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_ctl_t                    ctl_i,
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  output logic signed [DataWidth-1:0] sat_o
);

  logic signed [2*DataWidth-1:0] prod_q;
  logic                          pv_q;
  logic signed [AccW-1:0]        acc_q, acc_d;
  logic signed [AccW-17:0]       sh;
  localparam logic signed [AccW-17:0] Max = (AccW-16)'(64'sh7FFFFFFF);
  localparam logic signed [AccW-17:0] Min = -(AccW-16)'(64'sh80000000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.acc_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign sh = acc_q[AccW-1:16];

  always_comb begin
    if (sh > Max) begin
      sat_o = 32'sh7FFFFFFF;
    end else if (sh < Min) begin
      sat_o = 32'sh80000000;
    end else begin
      sat_o = sh[DataWidth-1:0];
    end
  end

endmodule

FILE: rtl/tensor_contraction_engine.sv
// Channel  | Direction | Signals                         | Transfer when
// ---------+-----------+---------------------------------+----------------------
// command  | in        | start_i, item_i, busy_o         | start_i && !busy_o
// result   | out       | res_valid_o, res_o              | res_valid_o (1 cycle)
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i | cfg_we_i
//
// Loads are written into the addressed store when accepted and leave busy_o
// low. A contraction read holds busy_o through six index steps on one shared
// 26-bit multiplier, a check, then one operand fetch and one multiply-accumulate
// per inner element through the single read port of each store. The strobe
// follows with busy_o already low; a read that fails its checks skips the fetch
// loop. Copy reads skip the index steps and the check. Reset clears control and
// configuration; the stores are not cleared. Results cannot be stalled; each is
// shown for exactly one cycle.
module tensor_contraction_engine
  import tce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  item_t               item_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output res_t                res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
`include "tensor_contraction_engine_assert.svh"

  // configuration
  logic [1:0]      mode_q;
  logic [CntW-1:0] batch_q, row_q, inner_q, slice_q, col_q, vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OUTER;
      batch_q <= CntW'(1);
      row_q   <= CntW'(1);
      inner_q <= CntW'(1);
      slice_q <= CntW'(1);
      col_q   <= CntW'(1);
      vb_q    <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_MODE:   mode_q  <= cfg_data_i[1:0];
        CFG_BATCH:  batch_q <= cfg_data_i;
        CFG_ROW:    row_q   <= cfg_data_i;
        CFG_INNER:  inner_q <= cfg_data_i;
        CFG_SLICE:  slice_q <= cfg_data_i;
        CFG_COL:    col_q   <= cfg_data_i;
        CFG_VBATCH: vb_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand stores
  logic [DataWidth-1:0] a_mem [ADepth];
  logic [DataWidth-1:0] b_mem [BDepth];
  logic [AddrW-1:0]     a_ra, b_ra;
  logic [DataWidth-1:0] a_rd_q, b_rd_q;
  logic                 load_a, load_b;

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      a_mem[item_i.address] <= item_i.value;
    end
    a_rd_q <= a_mem[a_ra];
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_mem[item_i.address] <= item_i.value;
    end
    b_rd_q <= b_mem[b_ra];
  end

  // sequencer state
  state_e state_q, state_d;
  item_t  req_q;
  logic [WAddrW-1:0] t1_q, t2_q, abase_q, bbase_q, aptr_q, bptr_q;
  logic [WAddrW-1:0] t1_d, t2_d, abase_d, bbase_d, aptr_d, bptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d, vbi_q, vbi_d;
  logic              err_q, err_d;
  logic              accept;
  logic              res_v_d, res_v_q;
  res_t              res_d, res_q;
  mac_ctl_t          mac_ctl;
  logic signed [DataWidth-1:0] sat;

  // the one shared index multiplier
  logic [WAddrW-1:0] mul_x, mul_y, mul_p;
  assign mul_p = WAddrW'(mul_x * mul_y);

  // one restoring remainder step: subtract d << k when it fits
  function automatic logic [CntW-1:0] rem_step(logic [CntW-1:0] r, logic [CntW-1:0] d,
                                               logic [2:0] k);
    logic [CntW+3:0] dsh;
    dsh = {4'd0, d} << k;
    return ({4'd0, r} >= dsh) ? r - dsh[CntW-1:0] : r;
  endfunction

  assign accept = start_i && !busy_o;
  assign load_a = accept && (item_i.operation == OP_LOAD_A);
  assign load_b = accept && (item_i.operation == OP_LOAD_B);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_i.operation == OP_READ) begin
          state_d = (mode_e'(mode_q) == MODE_COPY) ? ST_COPY : ST_MUL1;
        end
      end
      ST_COPY:   state_d = ST_FINISH;
      ST_MUL1:   state_d = ST_MUL1B;
      ST_MUL1B:  state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_MUL2B;
      ST_MUL2B:  state_d = ST_MUL3;
      ST_MUL3:   state_d = ST_MUL4;
      ST_MUL4:   state_d = ST_CHECK;
      ST_CHECK:  state_d = err_d ? ST_FINISH : ST_RDREQ;
      ST_RDREQ:  state_d = ST_MAC;
      ST_MAC:    state_d = (cnt_q == CntW'(1)) ? ST_DRAIN : ST_MAC;
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    t1_d = t1_q; t2_d = t2_q; abase_d = abase_q; bbase_d = bbase_q;
    aptr_d = aptr_q; bptr_d = bptr_q; cnt_d = cnt_q; vbi_d = vbi_q;
    err_d = err_q;
    mul_x = '0; mul_y = '0;
    a_ra = aptr_q[AddrW-1:0];
    b_ra = bptr_q[AddrW-1:0];
    mac_ctl = '0;
    res_v_d = 1'b0;
    res_d = '0;
    case (state_q)
      ST_IDLE: begin
        err_d = 1'b0;
        vbi_d = {1'b0, item_i.batch_idx};
        a_ra  = item_i.address;
        mac_ctl.clear = 1'b1;
      end
      ST_COPY: begin
        a_ra   = req_q.address;
        aptr_d = '0;
      end
      ST_MUL1: begin
        // batch*row + row for A
        mul_x = WAddrW'(req_q.batch_idx);
        mul_y = WAddrW'(row_q);
        t1_d  = mul_p + WAddrW'(req_q.row_idx);
        // batch mod vector_batch: one restoring step per index state up to ST_MUL3. A
        // vector batch of 2 or more leaves a quotient under 32, so five steps
        // do; a vector batch of 1 broadcasts and ignores the remainder.
        vbi_d = rem_step(vbi_q, vb_q, 3'd4);
      end
      ST_MUL1B: begin
        // batch*slice + slice for B
        mul_x = WAddrW'(req_q.batch_idx);
        mul_y = WAddrW'(slice_q);
        t2_d  = mul_p + WAddrW'(req_q.slice_idx);
        vbi_d = rem_step(vbi_q, vb_q, 3'd3);
      end
      ST_MUL2: begin
        mul_x = t1_q;
        mul_y = WAddrW'(inner_q);
        abase_d = mul_p;
        vbi_d = rem_step(vbi_q, vb_q, 3'd2);
      end
      ST_MUL2B: begin
        mul_x = t2_q;
        mul_y = WAddrW'(inner_q);
        t2_d  = mul_p;
        vbi_d = rem_step(vbi_q, vb_q, 3'd1);
      end
      ST_MUL3: begin
        mul_x = t2_q;
        mul_y = WAddrW'(col_q);
        t2_d  = mul_p + WAddrW'(req_q.col_idx);
        vbi_d = rem_step(vbi_q, vb_q, 3'd0);
      end
      ST_MUL4: begin
        if (mode_e'(mode_q) == MODE_MATVEC) begin
          mul_x = (vb_q == CntW'(1)) ? '0 : WAddrW'(vbi_q);
          mul_y = WAddrW'(inner_q);
          bbase_d = mul_p;
        end else if (mode_e'(mode_q) == MODE_MATMUL) begin
          bbase_d = t2_q;
          mul_x = WAddrW'(inner_q) - WAddrW'(1);
          mul_y = WAddrW'(col_q);
          t1_d  = mul_p;
        end else begin
          abase_d = WAddrW'(req_q.row_idx);
          bbase_d = WAddrW'(req_q.col_idx);
        end
      end
      ST_CHECK: begin
        aptr_d = abase_q;
        bptr_d = bbase_q;
        case (mode_e'(mode_q))
          MODE_OUTER: begin
            cnt_d = CntW'(1);
            err_d = !dim_ok(row_q) || !dim_ok(col_q) ||
                    {1'b0, req_q.row_idx} >= row_q || {1'b0, req_q.col_idx} >= col_q;
          end
          MODE_MATVEC: begin
            cnt_d = inner_q;
            err_d = !dim_ok(batch_q) || !dim_ok(row_q) || !dim_ok(inner_q) ||
                    !dim_ok(vb_q) || {1'b0, req_q.batch_idx} >= batch_q ||
                    {1'b0, req_q.row_idx} >= row_q ||
                    abase_q + WAddrW'(inner_q) > WAddrW'(ADepth) ||
                    bbase_q + WAddrW'(inner_q) > WAddrW'(BDepth);
          end
          default: begin
            cnt_d = inner_q;
            err_d = !dim_ok(batch_q) || !dim_ok(row_q) || !dim_ok(inner_q) ||
                    !dim_ok(slice_q) || !dim_ok(col_q) ||
                    {1'b0, req_q.batch_idx} >= batch_q ||
                    {1'b0, req_q.slice_idx} >= slice_q ||
                    {1'b0, req_q.row_idx} >= row_q ||
                    {1'b0, req_q.col_idx} >= col_q ||
                    abase_q + WAddrW'(inner_q) > WAddrW'(ADepth) ||
                    bbase_q + t1_q >= WAddrW'(BDepth);
          end
        endcase
      end
      ST_RDREQ: begin
        // address for element 0 is on the port; advance
        aptr_d = aptr_q + WAddrW'(1);
        bptr_d = bptr_q + ((mode_e'(mode_q) == MODE_MATMUL) ? WAddrW'(col_q)
                                                          : WAddrW'(1));
      end
      ST_MAC: begin
        mac_ctl.acc_en = 1'b1;
        cnt_d  = cnt_q - CntW'(1);
        aptr_d = aptr_q + WAddrW'(1);
        bptr_d = bptr_q + ((mode_e'(mode_q) == MODE_MATMUL) ? WAddrW'(col_q)
                                                          : WAddrW'(1));
      end
      ST_DRAIN: ;
      ST_FINISH: begin
        res_v_d = 1'b1;
        res_d.error = err_q;
        if (err_q) begin
          res_d.result = '0;
        end else if (mode_e'(mode_q) == MODE_COPY) begin
          res_d.result = a_rd_q;
        end else begin
          res_d.result = sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_v_q <= 1'b0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= item_i;
    end
    t1_q <= t1_d; t2_q <= t2_d; abase_q <= abase_d; bbase_q <= bbase_d;
    aptr_q <= aptr_d; bptr_q <= bptr_d; vbi_q <= vbi_d;
    res_q <= res_d;
  end

  tce_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .sat_o  (sat)
  );

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  `TCE_ASSERT_NEXT(a_res_after_finish, state_q == ST_FINISH, res_valid_o)
  `TCE_ASSERT_IMP(a_res_only_idle, res_valid_o, state_q == ST_IDLE)
  `TCE_ASSERT_IMP(a_err_zero, res_valid_o && res_o.error, res_o.result == '0)
  `TCE_ASSERT_IMP(a_mac_cnt, state_q == ST_MAC, cnt_q != '0)

endmodule
